// ===== rtl/core/kms_pkg.sv =====
`timescale 1ns / 1ps
// Shared sizes and transfer types for the Kruskal spanning-tree edge selector.
// No dependencies; imported by every module of the block.
package kms_pkg;

   localparam int VERTICES  = 16;
   localparam int MAX_EDGES = 64;
   localparam int MAX_OUT   = 15;

   localparam int VTX_W = $clog2(VERTICES);
   localparam int W_W   = 16;
   localparam int IDX_W = $clog2(MAX_EDGES);
   localparam int CNT_W = $clog2(MAX_EDGES + 1);
   localparam int OUT_W = $clog2(MAX_OUT + 1);
   localparam int KEY_W = W_W + IDX_W;

   typedef struct packed {
      logic [VTX_W-1:0]      first_vertex;
      logic [VTX_W-1:0]      second_vertex;
      logic signed [W_W-1:0] edge_weight;
      logic                  edge_present;
      logic                  last_item;
   } req_type;

   typedef struct packed {
      logic [VTX_W-1:0]      tree_first;
      logic [VTX_W-1:0]      tree_second;
      logic signed [W_W-1:0] tree_weight;
      logic                  edge_valid;
      logic                  last_result;
      logic                  overflowed;
   } rsp_type;

   typedef struct packed {
      logic [VTX_W-1:0]      u;
      logic [VTX_W-1:0]      v;
      logic signed [W_W-1:0] w;
   } edge_type;

   typedef struct packed {
      logic start;
      logic first;
      logic clear;
   } scan_cmd_type;

   typedef struct packed {
      logic     done;
      logic     found;
      edge_type best;
   } scan_rsp_type;

endpackage

// ===== rtl/core/kms_edge_store.sv =====
`timescale 1ns / 1ps
// Edge store and minimum-search unit: one pass finds the smallest (weight, slot)
// key above the previous pick. Depends on kms_pkg.
module kms_edge_store import kms_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         load_en,
   input  edge_type     load_edge,
   input  scan_cmd_type cmd,
   output scan_rsp_type rsp,
   output logic         overflow
);

   // order by weight, then arrival slot; flip the sign bit for unsigned compare
   function automatic logic [KEY_W-1:0] key_of(edge_type e, logic [IDX_W-1:0] idx);
      key_of = {~e.w[W_W-1], e.w[W_W-2:0], idx};
   endfunction

   edge_type mem [MAX_EDGES];

   logic [CNT_W-1:0] count_ff, count_in;
   logic             ovf_ff, ovf_in;
   logic             active_ff, active_in;
   logic [CNT_W-1:0] rd_cnt_ff, rd_cnt_in;
   logic             rd_valid_ff;
   logic [IDX_W-1:0] rd_idx_ff;
   edge_type         rd_data_ff;
   logic             found_ff, found_in;
   logic [KEY_W-1:0] best_key_ff, best_key_in;
   edge_type         best_edge_ff, best_edge_in;
   logic             have_prev_ff, have_prev_in;
   logic [KEY_W-1:0] prev_key_ff, prev_key_in;
   logic             done_ff, done_in;

   logic             store_full;
   logic             write_en;
   logic             issue;
   logic [KEY_W-1:0] cand_key;
   logic             take;
   logic             pass_end;

   assign store_full = count_ff == CNT_W'(MAX_EDGES);
   assign write_en   = load_en && !store_full;
   assign issue      = active_ff && (rd_cnt_ff < count_ff);
   assign cand_key   = key_of(rd_data_ff, rd_idx_ff);
   assign take       = rd_valid_ff
                       && (!have_prev_ff || cand_key > prev_key_ff)
                       && (!found_ff || cand_key < best_key_ff);
   assign pass_end   = active_ff && !issue && !rd_valid_ff;

   always_comb begin
      count_in     = count_ff;
      ovf_in       = ovf_ff;
      active_in    = active_ff;
      rd_cnt_in    = rd_cnt_ff;
      found_in     = found_ff;
      best_key_in  = best_key_ff;
      best_edge_in = best_edge_ff;
      have_prev_in = have_prev_ff;
      prev_key_in  = prev_key_ff;
      done_in      = 1'b0;

      if (cmd.clear) begin
         count_in = '0;
         ovf_in   = 1'b0;
      end else if (load_en) begin
         if (store_full) begin
            ovf_in = 1'b1;
         end else begin
            count_in = count_ff + CNT_W'(1);
         end
      end

      if (cmd.start) begin
         active_in = 1'b1;
         rd_cnt_in = '0;
         found_in  = 1'b0;
         if (cmd.first) begin
            have_prev_in = 1'b0;
         end
      end else begin
         if (issue) begin
            rd_cnt_in = rd_cnt_ff + CNT_W'(1);
         end
         if (take) begin
            found_in     = 1'b1;
            best_key_in  = cand_key;
            best_edge_in = rd_data_ff;
         end
         if (pass_end) begin
            active_in = 1'b0;
            done_in   = 1'b1;
            if (found_ff) begin
               prev_key_in  = best_key_ff;
               have_prev_in = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         ovf_ff       <= 1'b0;
         active_ff    <= 1'b0;
         rd_cnt_ff    <= '0;
         rd_valid_ff  <= 1'b0;
         found_ff     <= 1'b0;
         have_prev_ff <= 1'b0;
         done_ff      <= 1'b0;
      end else begin
         count_ff     <= count_in;
         ovf_ff       <= ovf_in;
         active_ff    <= active_in;
         rd_cnt_ff    <= rd_cnt_in;
         rd_valid_ff  <= issue && !cmd.start;
         found_ff     <= found_in;
         have_prev_ff <= have_prev_in;
         done_ff      <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      best_key_ff  <= best_key_in;
      best_edge_ff <= best_edge_in;
      prev_key_ff  <= prev_key_in;
      rd_idx_ff    <= rd_cnt_ff[IDX_W-1:0];
   end

   // single write port on load, single registered read port for the search
   always_ff @(posedge clock) begin
      if (write_en) begin
         mem[count_ff[IDX_W-1:0]] <= load_edge;
      end
      if (issue) begin
         rd_data_ff <= mem[rd_cnt_ff[IDX_W-1:0]];
      end
   end

   assign rsp.done  = done_ff;
   assign rsp.found = found_ff;
   assign rsp.best  = best_edge_ff;
   assign overflow  = ovf_ff;

endmodule

// ===== rtl/core/kruskal_mst_edge_selector_top.sv =====
`timescale 1ns / 1ps
// Kruskal edge selector top: edges load at one transfer per cycle; the graph's last
// item starts the tree pass. Each search pass launches, reads the n stored edges over the
// single store read port, then ends and raises a done flag; each picked edge then walks
// union-find steps (at most VERTICES - 1 per endpoint), and the input stalls throughout
// the tree pass. Synchronous active-high reset empties the store, clears the overflow
// flag and makes each vertex its own parent.
module kruskal_mst_edge_selector_top import kms_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   typedef enum logic [6:0] {
      ST_LOAD   = 7'b0000001,
      ST_START  = 7'b0000010,
      ST_SCAN   = 7'b0000100,
      ST_FIND_A = 7'b0001000,
      ST_FIND_B = 7'b0010000,
      ST_PUSH   = 7'b0100000,
      ST_FLUSH  = 7'b1000000
   } state_type;

   function automatic rsp_type make_rsp(edge_type e, logic valid, logic last, logic ovf);
      rsp_type r;
      r.tree_first  = valid ? e.u : '0;
      r.tree_second = valid ? e.v : '0;
      r.tree_weight = valid ? e.w : '0;
      r.edge_valid  = valid;
      r.last_result = last;
      r.overflowed  = ovf;
      return r;
   endfunction

   state_type        state_ff, state_in;
   logic             first_ff, first_in;
   edge_type         cur_ff, cur_in;
   logic [VTX_W-1:0] x_ff, x_in;
   logic [VTX_W-1:0] ra_ff, ra_in;
   logic [VTX_W-1:0] parent_ff [VERTICES];
   edge_type         pend_ff, pend_in;
   logic             pend_valid_ff, pend_valid_in;
   logic [OUT_W-1:0] emitted_ff, emitted_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_data_ff, rsp_data_in;

   logic             req_accept;
   logic             keep_edge;
   edge_type         in_edge;
   logic             slot_free;
   logic [VTX_W-1:0] x_parent;
   logic             at_root;
   logic             par_we;
   logic             par_clear;
   logic             ovf;
   scan_cmd_type     scan_cmd;
   scan_rsp_type     scan_rsp;

   // the input side is only open while edges load
   assign req_stall  = state_ff != ST_LOAD;
   assign req_accept = req_valid && !req_stall;

   // drop items that are not list edges or name a vertex out of range
   assign keep_edge = req_data.edge_present
                      && (req_data.first_vertex < req_data.second_vertex)
                      && (int'(req_data.second_vertex) < VERTICES);

   assign in_edge.u = req_data.first_vertex;
   assign in_edge.v = req_data.second_vertex;
   assign in_edge.w = req_data.edge_weight;

   kms_edge_store u_store (
      .clock     (clock),
      .reset     (reset),
      .load_en   (req_accept && keep_edge),
      .load_edge (in_edge),
      .cmd       (scan_cmd),
      .rsp       (scan_rsp),
      .overflow  (ovf)
   );

   // output register frees when empty or when its transfer completes
   assign slot_free = !rsp_valid_ff || !rsp_stall;

   // one union-find step per cycle through the single parent read
   assign x_parent = parent_ff[x_ff];
   assign at_root  = x_parent == x_ff;

   always_comb begin
      state_in      = state_ff;
      first_in      = first_ff;
      cur_in        = cur_ff;
      x_in          = x_ff;
      ra_in         = ra_ff;
      pend_in       = pend_ff;
      pend_valid_in = pend_valid_ff;
      emitted_in    = emitted_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_data_in   = rsp_data_ff;
      par_we        = 1'b0;
      par_clear     = 1'b0;
      scan_cmd      = '0;

      unique case (state_ff)
         ST_LOAD: begin
            if (req_accept && req_data.last_item) begin
               first_in = 1'b1;
               state_in = ST_START;
            end
         end
         ST_START: begin
            // launch a search for the next edge in stable weight order
            scan_cmd.start = 1'b1;
            scan_cmd.first = first_ff;
            first_in       = 1'b0;
            state_in       = ST_SCAN;
         end
         ST_SCAN: begin
            if (scan_rsp.done) begin
               if (scan_rsp.found && (emitted_ff < OUT_W'(MAX_OUT))) begin
                  cur_in   = scan_rsp.best;
                  x_in     = scan_rsp.best.u;
                  state_in = ST_FIND_A;
               end else begin
                  state_in = ST_FLUSH;
               end
            end
         end
         ST_FIND_A: begin
            if (at_root) begin
               ra_in    = x_ff;
               x_in     = cur_ff.v;
               state_in = ST_FIND_B;
            end else begin
               x_in = x_parent;
            end
         end
         ST_FIND_B: begin
            if (at_root) begin
               if (ra_ff != x_ff) begin
                  // join the two components: hang the first root under the second
                  par_we   = 1'b1;
                  state_in = ST_PUSH;
               end else begin
                  state_in = ST_START;
               end
            end else begin
               x_in = x_parent;
            end
         end
         ST_PUSH: begin
            // hold the newest tree edge back so the final one can carry last_result
            if (!pend_valid_ff) begin
               pend_in       = cur_ff;
               pend_valid_in = 1'b1;
               emitted_in    = emitted_ff + OUT_W'(1);
               state_in      = ST_START;
            end else if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = make_rsp(pend_ff, 1'b1, 1'b0, ovf);
               pend_in      = cur_ff;
               emitted_in   = emitted_ff + OUT_W'(1);
               state_in     = ST_START;
            end
         end
         ST_FLUSH: begin
            // release the held edge, or the empty-tree marker, then reset the graph
            if (slot_free) begin
               rsp_valid_in   = 1'b1;
               rsp_data_in    = make_rsp(pend_ff, pend_valid_ff, 1'b1, ovf);
               par_clear      = 1'b1;
               scan_cmd.clear = 1'b1;
               pend_valid_in  = 1'b0;
               emitted_in     = '0;
               state_in       = ST_LOAD;
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_LOAD;
         first_ff      <= 1'b0;
         pend_valid_ff <= 1'b0;
         emitted_ff    <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         first_ff      <= first_in;
         pend_valid_ff <= pend_valid_in;
         emitted_ff    <= emitted_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff      <= cur_in;
      x_ff        <= x_in;
      ra_ff       <= ra_in;
      pend_ff     <= pend_in;
      rsp_data_ff <= rsp_data_in;
   end

   // parent table: every vertex its own parent after reset and after each graph
   always_ff @(posedge clock) begin
      for (int i = 0; i < VERTICES; i++) begin
         if (reset || par_clear) begin
            parent_ff[i] <= VTX_W'(i);
         end else if (par_we && (ra_ff == VTX_W'(i))) begin
            parent_ff[i] <= x_ff;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== rtl/core/kms_checker.sv =====
`timescale 1ns / 1ps
// Port-level checks for the Kruskal edge selector, bound to the top level.
// Depends on kms_pkg and kruskal_mst_edge_selector_top.
module kms_checker import kms_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_stall,
   input req_type req_data,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input rsp_type rsp_data
);

   // a stalled result transfer holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("result payload changed while stalled");

   // the empty-tree marker closes its graph
   a_marker_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.edge_valid |-> rsp_data.last_result)
      else $error("empty-tree marker without last_result");

   // the empty-tree marker carries zero endpoints and weight
   a_marker_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.edge_valid |->
         rsp_data.tree_first == '0 && rsp_data.tree_second == '0
         && rsp_data.tree_weight == '0)
      else $error("empty-tree marker with non-zero fields");

   // only list edges are stored, so every tree edge has first below second
   a_edge_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.edge_valid |-> rsp_data.tree_first < rsp_data.tree_second)
      else $error("tree edge endpoints out of order");

   // the input closes once the final item of a graph is taken
   a_busy_after_last: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_data.last_item |=> req_stall)
      else $error("input open while the tree pass runs");

endmodule

bind kruskal_mst_edge_selector_top kms_checker u_kms_checker (.*);

// ===== tb/sv/mst_scoreboard_pkg.sv =====
`timescale 1ns / 1ps
// Scoreboard for the Kruskal spanning-tree edge selector: predicts tree edges per graph.
// Depends on kms_pkg for the transfer types and sizes.
package mst_scoreboard_pkg;
   import kms_pkg::*;

   class mst_scoreboard;
      edge_type         graph_edges[MAX_EDGES];
      int               edge_count;
      logic [VTX_W-1:0] parent[VERTICES];
      bit               overflow_seen;
      rsp_type          expected_tree[$];
      int               failures;

      function new();
         failures = 0;
         clear_graph();
      endfunction

      function void clear_graph();
         edge_count    = 0;
         overflow_seen = 1'b0;
         for (int i = 0; i < VERTICES; i++) begin
            parent[i] = VTX_W'(i);
         end
      endfunction

      function logic [VTX_W-1:0] root_of(input logic [VTX_W-1:0] x);
         int steps;
         steps = 0;
         while (parent[x] != x && steps < VERTICES) begin
            x = parent[x];
            steps++;
         end
         return x;
      endfunction

      // Store the edge if it is a list edge, and on the last item of a graph
      // sort stably by weight, scan with union-find and queue the tree edges.
      function void note_request(input req_type item);
         edge_type         sorted[MAX_EDGES];
         edge_type         cur;
         rsp_type          outs[MAX_OUT];
         int               j;
         int               n_out;
         logic [VTX_W-1:0] ra;
         logic [VTX_W-1:0] rb;
         if (item.edge_present && item.first_vertex < item.second_vertex) begin
            if (edge_count < MAX_EDGES) begin
               graph_edges[edge_count] = '{u: item.first_vertex, v: item.second_vertex,
                                           w: item.edge_weight};
               edge_count++;
            end else begin
               overflow_seen = 1'b1;
            end
         end
         if (!item.last_item) return;

         for (int i = 0; i < edge_count; i++) begin
            cur = graph_edges[i];
            j   = i;
            while (j > 0 && sorted[j-1].w > cur.w) begin
               sorted[j] = sorted[j-1];
               j--;
            end
            sorted[j] = cur;
         end

         n_out = 0;
         for (int i = 0; i < edge_count && n_out < MAX_OUT; i++) begin
            ra = root_of(sorted[i].u);
            rb = root_of(sorted[i].v);
            if (ra != rb) begin
               parent[ra]  = rb;
               outs[n_out] = '{tree_first: sorted[i].u, tree_second: sorted[i].v,
                               tree_weight: sorted[i].w, edge_valid: 1'b1,
                               last_result: 1'b0, overflowed: overflow_seen};
               n_out++;
            end
         end
         if (n_out == 0) begin
            outs[0]             = '0;
            outs[0].last_result = 1'b1;
            outs[0].overflowed  = overflow_seen;
            n_out               = 1;
         end else begin
            outs[n_out-1].last_result = 1'b1;
         end
         for (int i = 0; i < n_out; i++) begin
            expected_tree.push_back(outs[i]);
         end
         clear_graph();
      endfunction

      function void check_field(input string name, input logic signed [31:0] exp_val,
                                input logic signed [31:0] act_val);
         if (act_val !== exp_val) begin
            $error("%s: expected %0d, got %0d", name, exp_val, act_val);
            failures++;
         end
      endfunction

      function void check_result(input rsp_type got);
         rsp_type want;
         if (expected_tree.size() == 0) begin
            $error("tree result with nothing outstanding: %p", got);
            failures++;
            return;
         end
         want = expected_tree.pop_front();
         check_field("tree_first", want.tree_first, got.tree_first);
         check_field("tree_second", want.tree_second, got.tree_second);
         check_field("tree_weight", want.tree_weight, got.tree_weight);
         check_field("edge_valid", want.edge_valid, got.edge_valid);
         check_field("last_result", want.last_result, got.last_result);
         check_field("overflowed", want.overflowed, got.overflowed);
      endfunction

      function int pending();
         return expected_tree.size();
      endfunction
   endclass

endpackage

// ===== tb/sv/kruskal_mst_edge_selector_top_tb.sv =====
`timescale 1ns / 1ps
// Top-level testbench for the Kruskal spanning-tree edge selector: directed graphs, then
// random graphs under random idling and one long result hold-off. Depends on kms_pkg and
// mst_scoreboard_pkg.
module kruskal_mst_edge_selector_top_tb;
   import kms_pkg::*;
   import mst_scoreboard_pkg::*;

   localparam int EDGE_TARGET = 500;  // least number of items sent in the random part
   localparam int HOLD_CYCLES = 1500; // long enough to outlast a small graph's tree pass

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_stall;
   rsp_type rsp_data;

   // calm switches off idling on both sides; hold_request asks for the long hold-off.
   bit calm;
   bit hold_request;

   mst_scoreboard sb;

   kruskal_mst_edge_selector_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Offer one item from a falling edge and return at the falling edge after its
   // transfer. Idle cycles drop valid; a back-to-back item keeps valid high, so
   // valid sees exactly one assignment per falling edge.
   task automatic push_item(input logic [VTX_W-1:0] u, input logic [VTX_W-1:0] v,
                            input logic signed [W_W-1:0] w, input logic present,
                            input logic last);
      req_type item;
      item = '{first_vertex: u, second_vertex: v, edge_weight: w,
               edge_present: present, last_item: last};
      while (!calm && $urandom_range(99) < 33) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (req_stall !== 1'b0) @(posedge clock);
      sb.note_request(item);
      @(negedge clock);
   endtask

   // Result side: random stalls, one long hold-off on request, none while calm.
   initial begin
      int hold_left;
      bit hold_used;
      hold_left = 0;
      hold_used = 1'b0;
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request && !hold_used) begin
            hold_used = 1'b1;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
         end else begin
            rsp_stall <= !calm && ($urandom_range(99) < 33);
         end
      end
   end

   // Check every result transfer against the oldest predicted tree edge.
   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && rsp_stall == 1'b0) begin
         sb.check_result(rsp_data);
      end
   end

   // Hard stop well beyond the slowest legal run.
   initial begin
      #12_000_000;
      $display("Verification failed");
      $finish;
   end

   initial begin
      int                    good_items;
      int                    graph_no;
      int                    n_edges;
      int                    roll;
      int                    drain_cycles;
      bit                    tie_weights;
      logic [VTX_W-1:0]      u;
      logic [VTX_W-1:0]      v;
      logic signed [W_W-1:0] w;
      logic                  present;
      logic                  last;

      sb           = new();
      calm         = 1'b0;
      hold_request = 1'b0;
      reset        = 1'b1;
      req_valid    = 1'b0;
      req_data     = '0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Single edge at the extreme vertices and the most negative weight.
      push_item(4'd0, 4'd15, 16'sh8000, 1'b1, 1'b1);

      // Reversed and self-loop edges are dropped; a bare end marker then gives
      // the empty-tree marker.
      push_item(4'd5, 4'd3, 16'sd100, 1'b1, 1'b0);
      push_item(4'd7, 4'd7, 16'sh7fff, 1'b1, 1'b0);
      push_item(4'd15, 4'd0, 16'sd0, 1'b0, 1'b1);

      // An item without an edge is ignored even though its vertices look valid.
      push_item(4'd1, 4'd2, 16'sd9, 1'b0, 1'b0);
      push_item(4'd1, 4'd2, 16'sh7fff, 1'b1, 1'b1);

      // Equal weights must keep arrival order; the triangle closes a cycle.
      push_item(4'd0, 4'd1, 16'sd5, 1'b1, 1'b0);
      push_item(4'd1, 4'd2, 16'sd5, 1'b1, 1'b0);
      push_item(4'd0, 4'd2, 16'sd5, 1'b1, 1'b0);
      push_item(4'd2, 4'd3, -16'sd1, 1'b1, 1'b0);
      push_item(4'd1, 4'd3, 16'sd0, 1'b1, 1'b1);

      // Star from vertex 0: builds the deepest parent chain and the full tree.
      for (int i = 1; i < VERTICES; i++) begin
         push_item(4'd0, VTX_W'(i), W_W'(i), 1'b1, (i == VERTICES - 1));
      end

      // Random graphs: mostly small, a few past the store size to raise overflow.
      good_items = 0;
      graph_no   = 0;
      while (good_items < EDGE_TARGET) begin
         if (graph_no == 2 || graph_no == 7 || $urandom_range(24) == 0) begin
            n_edges = $urandom_range(84, 76);
         end else begin
            n_edges = $urandom_range(14, 1);
         end
         tie_weights = ($urandom_range(2) == 0);
         for (int k = 0; k < n_edges; k++) begin
            // Quiet stretch in the middle; long hold-off early on.
            calm         <= (good_items >= 200 && good_items < 320);
            hold_request <= (good_items >= 80);
            last = (k == n_edges - 1);
            roll = $urandom_range(99);
            if (roll < 85) begin
               u       = VTX_W'($urandom_range(14));
               v       = VTX_W'($urandom_range(15, u + 1));
               present = 1'b1;
            end else if (roll < 93) begin
               u       = VTX_W'($urandom_range(15));
               v       = VTX_W'($urandom_range(u, 0));
               present = 1'b1;
            end else begin
               u       = VTX_W'($urandom);
               v       = VTX_W'($urandom);
               present = 1'b0;
            end
            case ($urandom_range(9))
               0:       w = 16'sh8000;
               1:       w = 16'sh7fff;
               default: w = tie_weights ? W_W'($urandom_range(4) - 2) : W_W'($urandom);
            endcase
            good_items++;
            push_item(u, v, w, present, last);
         end
         graph_no++;
      end
      req_valid <= 1'b0;
      calm      <= 1'b0;

      // Drain outstanding tree edges, then allow the block to settle.
      drain_cycles = 0;
      while (sb.pending() != 0 && drain_cycles < 200000) begin
         @(posedge clock);
         drain_cycles++;
      end
      repeat (200) @(posedge clock);
      if (sb.pending() != 0) begin
         $error("%0d tree results never arrived", sb.pending());
      end
      if (sb.failures == 0 && sb.pending() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
